@@ rtl/assert_macros.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define BDD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define BDD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bdd_pkg.sv @@
package bdd_pkg;

  localparam int RING_DEPTH_LOG2 = 10;
  localparam int RING_DEPTH      = 1 << RING_DEPTH_LOG2;
  localparam int SAMPLE_W        = 16;
  localparam int SUM_W           = SAMPLE_W + RING_DEPTH_LOG2;
  localparam int AVG_W           = 16;
  localparam int GAIN_W          = 8;
  localparam int SHIFT_W         = 4;
  localparam int PROD_W          = GAIN_W + AVG_W;

  localparam int IN_DATA_W       = 16;
  localparam int OUT_DATA_W      = 24;
  localparam int CFG_INDEX_W     = 8;
  localparam int CFG_DATA_W      = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_GAIN  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_SHIFT = CFG_INDEX_W'(1);

endpackage

@@ rtl/battery_disconnect_detector_top.sv @@
// Battery disconnect detector: one voltage sample per item goes into a ring of
// 1024 samples, and each item yields the boxcar average of the ring (new sample
// included) and a flag that is set when the sample is below
// (threshold_gain * average) >> threshold_shift, truncated to 16 bits.
// The block takes one item per clock cycle while the output is not stalled, and
// its result passes stages 1, 2 and 3 and the output register; the ring memory
// is read in the cycle an item is accepted and written back with the new sample
// when the item leaves stage 1, while a running sum is updated in that same step.
// Ring entries that have not yet been written since reset count as zero, so
// no clearing pass is needed and items are taken from the first cycle after
// reset. Configuration is written through the cfg port (index 0: gain,
// index 1: shift) and other indexes are ignored.
`include "assert_macros.svh"

module battery_disconnect_detector_top
  import bdd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Input item stream.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,   // [15:0] voltage_sample
  // Result item stream.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,   // [0] disconnected, [16:1] average_voltage,
                                            // [23:17] zero
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PTR_W = RING_DEPTH_LOG2;

  logic [GAIN_W-1:0]   threshold_gain;
  logic [SHIFT_W-1:0]  threshold_shift;

  logic [PTR_W-1:0]    wp;
  logic                wrapped;
  logic [SUM_W-1:0]    running_sum;
  logic [SUM_W-1:0]    sum_next;

  logic                s1_valid, s2_valid, s3_valid;
  logic                s1_move, s2_move, s3_move;
  logic                out_free;
  logic                in_accept;

  logic [SAMPLE_W-1:0] s1_sample;
  logic [PTR_W-1:0]    s1_slot;
  logic                s1_old_ok;
  logic [SAMPLE_W-1:0] old_sample;

  logic [AVG_W-1:0]    s2_avg;
  logic [SAMPLE_W-1:0] s2_sample;

  logic [PROD_W-1:0]   s3_product;
  logic [AVG_W-1:0]    s3_avg;
  logic [SAMPLE_W-1:0] s3_sample;
  logic [AVG_W-1:0]    threshold;

  logic [AVG_W-1:0]    out_avg;
  logic                out_disc;

  logic                ram_we;
  logic                ram_re;
  logic [SAMPLE_W-1:0] ram_rdata;

  // Each stage moves when the stage after it is empty or moving itself.
  assign out_free  = !m_tvalid || m_tready;
  assign s3_move   = s3_valid && out_free;
  assign s2_move   = s2_valid && (!s3_valid || s3_move);
  assign s1_move   = s1_valid && (!s2_valid || s2_move);
  assign s_tready  = !rst && (!s1_valid || s1_move);
  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Read the slot in the accept cycle; write it back when the item leaves stage 1.
  // The read data stays put while stage 1 stalls, since no new read is issued.
  assign ram_re = in_accept;
  assign ram_we = s1_move;

  bdd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_slot),
    .wdata (s1_sample),
    .re    (ram_re),
    .raddr (wp),
    .rdata (ram_rdata)
  );

  // Until the pointer has wrapped once, the slot being read was never written.
  assign old_sample = s1_old_ok ? ram_rdata : '0;
  assign sum_next   = running_sum - SUM_W'(old_sample) + SUM_W'(s1_sample);
  assign threshold  = AVG_W'(s3_product >> threshold_shift);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_gain  <= '0;
      threshold_shift <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_THRESHOLD_GAIN:  threshold_gain  <= cfg_data[GAIN_W-1:0];
        CFG_THRESHOLD_SHIFT: threshold_shift <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp          <= '0;
      wrapped     <= 1'b0;
      running_sum <= '0;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (in_accept) begin
        wp <= wp + 1'b1;
        if (wp == PTR_W'(RING_DEPTH - 1)) begin
          wrapped <= 1'b1;
        end
      end
      if (s1_move) begin
        running_sum <= sum_next;
      end
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
      if (s2_move) begin
        s3_valid <= 1'b1;
      end else if (s3_move) begin
        s3_valid <= 1'b0;
      end
      if (s3_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample <= s_tdata[SAMPLE_W-1:0];
      s1_slot   <= wp;
      s1_old_ok <= wrapped;
    end
    if (s1_move) begin
      s2_avg    <= AVG_W'(sum_next[SUM_W-1 -: SAMPLE_W]);
      s2_sample <= s1_sample;
    end
    if (s2_move) begin
      s3_product <= PROD_W'(s2_avg) * PROD_W'(threshold_gain);
      s3_avg     <= s2_avg;
      s3_sample  <= s2_sample;
    end
    if (s3_move) begin
      out_avg  <= s3_avg;
      out_disc <= AVG_W'(s3_sample) < threshold;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - AVG_W - 1){1'b0}}, out_avg, out_disc};

  `BDD_ASSERT(a_ring_no_overlap, ram_we && ram_re |-> s1_slot != wp,
              "ring write and read hit the same slot")
  `BDD_ASSERT(a_wrapped_sticks, wrapped |=> wrapped,
              "ring wrap flag cleared outside reset")
  `BDD_ASSERT(a_pointer_steps, in_accept |=> wp == PTR_W'($past(wp) + 1'b1),
              "write pointer did not advance by one slot")
  `BDD_ASSERT(a_result_source, $rose(m_tvalid) |-> $past(s3_valid),
              "result appeared without an item in the last stage")

endmodule

@@ rtl/bdd_ram.sv @@
module bdd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
